// ===== sv/gfw_pkg.sv =====
// ----------------------------------------------------------------------------
// gfw_pkg
// Shared types and constants for the gap framed word FIFO.
// ----------------------------------------------------------------------------
package gfw_pkg;

	typedef logic [1:0]  action_t;
	typedef logic [15:0] word_t;
	typedef logic [7:0]  byte_t;

	localparam action_t ACT_TICK = 2'd0;
	localparam action_t ACT_BYTE = 2'd1;
	localparam action_t ACT_READ = 2'd2;

	localparam word_t GAP_THRESHOLD_RESET = 16'd10;
	localparam word_t IDLE_MAX            = 16'hFFFF;

	typedef struct packed {
		logic  wr_en;
		logic  rd_en;
		word_t wr_data;
	} store_req_t;

endpackage

// ===== sv/gap_framed_word_fifo.sv =====
// ----------------------------------------------------------------------------
// gap_framed_word_fifo
// Frames received bytes into 16-bit words by idle gaps and queues them in a
// small overwriting ring store.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item transfers at a rising edge with start high and
//   busy low. busy is always low, so one command is taken every cycle.
//   action selects tick, received byte or read; rx_byte is used for bytes.
//   Config: cfg_we with cfg_wdata writes gap_threshold (reset value 10);
//   write it only while no read response is pending.
//   Response: a read gives one result, done high for exactly one cycle, the
//   cycle after the read transfers (done is registered, and so is the read of
//   the store memory). word holds the oldest word, word_valid is 1; on an
//   empty store word is 0 and word_valid 0. Ticks and bytes give no result.
//   The receiver cannot stall; each result must be taken in its cycle.
//   Reset clears idle count, held byte, pointers and full flag at once; the
//   store memory itself is not cleared, no entry is read before it is written.
// ----------------------------------------------------------------------------
module gap_framed_word_fifo #(
	parameter int STORE_DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  gfw_pkg::action_t action,
	input  gfw_pkg::byte_t   rx_byte,
	input  logic             cfg_we,
	input  gfw_pkg::word_t   cfg_wdata,
	output logic             done,
	output gfw_pkg::word_t   word,
	output logic             word_valid
);
	import gfw_pkg::*;

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	store_req_t    req;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	word_t         rd_data;
	logic          rsp_s1;
	logic          hit_s1;
	logic          accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	gfw_ctrl #(
		.STORE_DEPTH(STORE_DEPTH),
		.AW         (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.action   (action),
		.rx_byte  (rx_byte),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr),
		.rsp_s1   (rsp_s1),
		.hit_s1   (hit_s1)
	);

	gfw_store #(
		.STORE_DEPTH(STORE_DEPTH),
		.AW         (AW)
	) u_store (
		.clk    (clk),
		.req    (req),
		.wr_addr(wr_addr),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign done       = rsp_s1;
	assign word_valid = hit_s1;
	assign word       = hit_s1 ? rd_data : '0;

endmodule

// ===== sv/gfw_store.sv =====
// ----------------------------------------------------------------------------
// gfw_store
// Word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gfw_store #(
	parameter int STORE_DEPTH = 2,
	parameter int AW          = 1
) (
	input  logic                clk,
	input  gfw_pkg::store_req_t req,
	input  logic [AW-1:0]       wr_addr,
	input  logic [AW-1:0]       rd_addr,
	output gfw_pkg::word_t      rd_data
);
	import gfw_pkg::*;

	word_t mem [STORE_DEPTH];
	word_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/gfw_ctrl.sv =====
// ----------------------------------------------------------------------------
// gfw_ctrl
// Idle counting, byte framing, ring pointers and read response timing.
// ----------------------------------------------------------------------------
module gfw_ctrl #(
	parameter int STORE_DEPTH = 2,
	parameter int AW          = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  gfw_pkg::action_t     action,
	input  gfw_pkg::byte_t       rx_byte,
	input  logic                 cfg_we,
	input  gfw_pkg::word_t       cfg_wdata,
	output gfw_pkg::store_req_t  req,
	output logic [AW-1:0]        wr_addr,
	output logic [AW-1:0]        rd_addr,
	output logic                 rsp_s1,
	output logic                 hit_s1
);
	import gfw_pkg::*;

	localparam logic [AW-1:0] LAST = AW'(STORE_DEPTH - 1);

	word_t         thr_q;
	word_t         idle_q;
	byte_t         high_q;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic          full_q;

	logic          empty;
	logic          push;
	logic          pop;
	logic [AW-1:0] wp_nxt;
	logic [AW-1:0] rp_nxt;

	assign empty  = (wp_q == rp_q) && !full_q;
	assign wp_nxt = (wp_q == LAST) ? '0 : wp_q + 1'b1;
	assign rp_nxt = (rp_q == LAST) ? '0 : rp_q + 1'b1;

	always_comb begin
		push = 1'b0;
		pop  = 1'b0;
		if (accept) begin
			case (action)
				ACT_BYTE: push = (idle_q <= thr_q);
				ACT_READ: pop  = !empty;
				default:  ;
			endcase
		end
	end

	assign req.wr_en   = push;
	assign req.rd_en   = pop;
	assign req.wr_data = {high_q, rx_byte};
	assign wr_addr     = wp_q;
	assign rd_addr     = rp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= GAP_THRESHOLD_RESET;
			idle_q <= '0;
			high_q <= '0;
			wp_q   <= '0;
			rp_q   <= '0;
			full_q <= 1'b0;
			rsp_s1 <= 1'b0;
			hit_s1 <= 1'b0;
		end else begin
			rsp_s1 <= accept && (action == ACT_READ);
			hit_s1 <= pop;
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (accept) begin
				case (action)
					ACT_TICK: begin
						if (idle_q != IDLE_MAX) begin
							idle_q <= idle_q + 16'd1;
						end
					end
					ACT_BYTE: begin
						idle_q <= '0;
						if (!push) begin
							high_q <= rx_byte;
						end else begin
							// advance oldest with the write when overwriting
							wp_q <= wp_nxt;
							if (full_q) begin
								rp_q <= rp_nxt;
							end
							full_q <= (wp_nxt == (full_q ? rp_nxt : rp_q));
						end
					end
					ACT_READ: begin
						if (pop) begin
							rp_q   <= rp_nxt;
							full_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== tb/sv/gap_framed_word_fifo_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_framed_word_fifo_tb
// Self-checking bench: drives ticks, bytes, reads and unused commands with
// random start gaps, predicts framing and ring store contents per transfer,
// and compares every read response field by field in arrival order.
// ----------------------------------------------------------------------------
module gap_framed_word_fifo_tb;
	import gfw_pkg::*;

	localparam int      DEPTH       = 2;
	localparam int      CYCLE_LIMIT = 1000000;
	localparam action_t ACT_UNUSED  = 2'd3;

	typedef struct {
		word_t data;
		logic  valid;
	} read_result_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	action_t action;
	byte_t   rx_byte;
	logic    cfg_we;
	word_t   cfg_wdata;
	logic    done;
	word_t   word;
	logic    word_valid;

	word_t        gap_thr;
	word_t        idle_cnt;
	byte_t        high_byte;
	word_t        ring [DEPTH];
	int           wr_idx;
	int           rd_idx;
	logic         ring_full;
	read_result_t pending_reads [$];

	int err_cnt;
	int cycle_cnt;
	int item_cnt;
	int read_cnt;
	int word_cnt;
	int overwrite_cnt;
	int idle_pct;

	gap_framed_word_fifo #(
		.STORE_DEPTH(DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.rx_byte    (rx_byte),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.done       (done),
		.word       (word),
		.word_valid (word_valid)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d reads outstanding", cycle_cnt,
				pending_reads.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		err_cnt++;
	endtask

	// Frame one accepted command into the predicted state.
	function automatic void frame_command(action_t act, byte_t data);
		read_result_t res;
		case (act)
		ACT_TICK: begin
			if (idle_cnt != IDLE_MAX)
				idle_cnt++;
		end
		ACT_BYTE: begin
			if (idle_cnt > gap_thr) begin
				high_byte = data;
			end else begin
				ring[wr_idx] = {high_byte, data};
				if (ring_full) begin
					rd_idx = (rd_idx + 1) % DEPTH;
					overwrite_cnt++;
				end
				wr_idx    = (wr_idx + 1) % DEPTH;
				ring_full = (wr_idx == rd_idx);
			end
			idle_cnt = '0;
		end
		ACT_READ: begin
			if (wr_idx == rd_idx && !ring_full) begin
				res.data  = '0;
				res.valid = 1'b0;
			end else begin
				res.data  = ring[rd_idx];
				res.valid = 1'b1;
				rd_idx    = (rd_idx + 1) % DEPTH;
				ring_full = 1'b0;
			end
			pending_reads.push_back(res);
		end
		default: ;
		endcase
	endfunction

	always @(posedge clk) begin : monitor
		read_result_t exp_res;
		if (arst_n) begin
			if (done) begin
				if (pending_reads.size() == 0) begin
					report_mismatch($sformatf("response with no read pending: word %h valid %b",
						word, word_valid));
				end else begin
					exp_res = pending_reads.pop_front();
					read_cnt++;
					if (exp_res.valid)
						word_cnt++;
					if (word !== exp_res.data)
						report_mismatch($sformatf("word %h, expected %h", word, exp_res.data));
					if (word_valid !== exp_res.valid)
						report_mismatch($sformatf("word_valid %b, expected %b", word_valid,
							exp_res.valid));
				end
			end
			if (start && !busy)
				frame_command(action, rx_byte);
			if (cfg_we)
				gap_thr = cfg_wdata;
		end
	end

	task automatic send_item(action_t act, byte_t data);
		while ($urandom_range(99) < idle_pct) begin
			start   <= 1'b0;
			action  <= action_t'($urandom);
			rx_byte <= byte_t'($urandom);
			@(posedge clk);
		end
		start   <= 1'b1;
		action  <= act;
		rx_byte <= data;
		do @(posedge clk); while (busy);
		if (act != ACT_UNUSED)
			item_cnt++;
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_item(ACT_TICK, byte_t'($urandom));
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_gap(word_t value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_empty_and_unused();
		send_item(ACT_READ, 8'h00);
		send_item(ACT_UNUSED, 8'hFF);
		send_item(ACT_READ, 8'hFF);
		send_item(ACT_BYTE, 8'h3C);
		send_item(ACT_READ, 8'h00);
		send_item(ACT_READ, 8'h00);
	endtask

	task automatic test_default_framing();
		send_ticks(11);
		send_item(ACT_BYTE, 8'hFF);
		send_item(ACT_BYTE, 8'h00);
		send_ticks(10);
		send_item(ACT_BYTE, 8'h81);
		send_item(ACT_READ, 8'h00);
		send_item(ACT_READ, 8'h00);
	endtask

	task automatic test_overwrite();
		send_item(ACT_BYTE, 8'h11);
		send_item(ACT_BYTE, 8'h22);
		send_item(ACT_BYTE, 8'h33);
		send_item(ACT_READ, 8'h00);
		send_item(ACT_BYTE, 8'h44);
		send_item(ACT_BYTE, 8'h55);
		send_item(ACT_READ, 8'h00);
		send_item(ACT_READ, 8'h00);
		send_item(ACT_READ, 8'h00);
	endtask

	task automatic test_gap_extremes();
		set_gap(16'h0000);
		send_item(ACT_BYTE, 8'h01);
		send_ticks(1);
		send_item(ACT_BYTE, 8'hAA);
		send_item(ACT_BYTE, 8'h55);
		send_item(ACT_READ, 8'h00);
		send_item(ACT_READ, 8'h00);
		set_gap(16'hFFFF);
		send_ticks(20);
		send_item(ACT_BYTE, 8'h12);
		send_item(ACT_READ, 8'h00);
	endtask

	task automatic random_phase(word_t thr, int n_items, int idle);
		int stop_at;
		int pick;
		int in_gap;
		int gap_cap;
		set_gap(thr);
		idle_pct = idle;
		stop_at  = item_cnt + n_items;
		in_gap   = (thr > 4) ? 4 : int'(thr);
		gap_cap  = (thr > 12) ? 8 : int'(thr) + 3;
		while (item_cnt < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				if (thr <= 12 && $urandom_range(1))
					send_ticks(int'(thr) + 1 + $urandom_range(2));
				else
					send_ticks($urandom_range(gap_cap));
				send_item(ACT_BYTE, byte_t'($urandom));
				send_ticks($urandom_range(in_gap));
				send_item(ACT_BYTE, byte_t'($urandom));
			end else if (pick < 75) begin
				send_item(ACT_READ, byte_t'($urandom));
			end else if (pick < 85) begin
				send_item(ACT_BYTE, byte_t'($urandom));
			end else if (pick < 95) begin
				send_ticks($urandom_range(gap_cap));
			end else begin
				send_item(ACT_UNUSED, byte_t'($urandom));
			end
		end
		idle_pct = 36;
	endtask

	task automatic test_random_traffic();
		random_phase(16'd10, 150, 36);
		random_phase(16'd0, 150, 36);
		random_phase(16'd3, 150, 0);
		random_phase(16'd1, 150, 36);
		random_phase(word_t'($urandom_range(7)), 150, 36);
		random_phase(16'hFFFF, 150, 36);
		random_phase(16'd2, 150, 36);
	endtask

	initial begin
		arst_n        <= 1'b0;
		start         <= 1'b0;
		action        <= ACT_TICK;
		rx_byte       <= '0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		gap_thr       = GAP_THRESHOLD_RESET;
		idle_cnt      = '0;
		high_byte     = '0;
		wr_idx        = 0;
		rd_idx        = 0;
		ring_full     = 1'b0;
		err_cnt       = 0;
		cycle_cnt     = 0;
		item_cnt      = 0;
		read_cnt      = 0;
		word_cnt      = 0;
		overwrite_cnt = 0;
		idle_pct      = 36;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_unused();
		test_default_framing();
		test_overwrite();
		test_gap_extremes();
		test_random_traffic();

		drain();
		repeat (3) @(posedge clk);
		$display("Sent %0d commands over %0d cycles: %0d reads checked, %0d returned words,",
			item_cnt, cycle_cnt, read_cnt, word_cnt);
		$display("%0d overwrites of a full store, gap threshold extremes, %0d mismatches",
			overwrite_cnt, err_cnt);
		if (err_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/gfw_pkg.sv
sv/gfw_store.sv
sv/gfw_ctrl.sv
sv/gap_framed_word_fifo.sv
tb/sv/gap_framed_word_fifo_tb.sv
